// ----- rtl/mtc_pkg.sv -----
`default_nettype none
package mtc_pkg;
  localparam int unsigned CoordWidth = 16;
  localparam int unsigned StepWidth  = 15;
  localparam logic [StepWidth-1:0] StepReset = 15'd480;
endpackage
`default_nettype wire

// ----- rtl/mtc_sqrt_cell.sv -----
`default_nettype none
// One root bit per cell: bring down two radicand bits, try (root<<2)|1.
module mtc_sqrt_cell #(
  parameter int unsigned R      = 17,
  parameter int unsigned SIDE_W = 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              vld_i,
  input  wire logic [2*R-1:0]    rad_i,
  input  wire logic [R:0]        rem_i,
  input  wire logic [R-1:0]      root_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output logic                   vld_o,
  output logic [2*R-1:0]         rad_o,
  output logic [R:0]             rem_o,
  output logic [R-1:0]           root_o,
  output logic [SIDE_W-1:0]      side_o
);
  logic [R+2:0] part;
  logic [R+2:0] trial;
  logic         ge;
  logic [R+2:0] diff;

  assign part  = {rem_i, rad_i[2*R-1 -: 2]};
  assign trial = {1'b0, root_i, 2'b01};
  assign ge    = part >= trial;
  assign diff  = ge ? part - trial : part;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_o  <= {rad_i[2*R-3:0], 2'b00};
      rem_o  <= diff[R:0];
      root_o <= {root_i[R-2:0], ge};
      side_o <= side_i;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/mtc_div_cell.sv -----
`default_nettype none
// One quotient bit per cell of a restoring divide; the divisor rides along.
module mtc_div_cell #(
  parameter int unsigned R      = 17,
  parameter int unsigned SIDE_W = 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              vld_i,
  input  wire logic [R-1:0]      num_i,
  input  wire logic [R-1:0]      rem_i,
  input  wire logic [R-1:0]      den_i,
  input  wire logic [R-1:0]      quo_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output logic                   vld_o,
  output logic [R-1:0]           num_o,
  output logic [R-1:0]           rem_o,
  output logic [R-1:0]           den_o,
  output logic [R-1:0]           quo_o,
  output logic [SIDE_W-1:0]      side_o
);
  logic [R:0] part;
  logic       ge;
  logic [R:0] diff;

  assign part = {rem_i, num_i[R-1]};
  assign ge   = part >= {1'b0, den_i};
  assign diff = ge ? part - {1'b0, den_i} : part;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_o  <= {num_i[R-2:0], 1'b0};
      rem_o  <= diff[R-1:0];
      den_o  <= den_i;
      quo_o  <= {quo_i[R-2:0], ge};
      side_o <= side_i;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/move_toward_clamped_step.sv -----
// Moves a signed Q11.4 point toward a goal by at most max_step (unsigned Q11.4).
// Input channel in_*: one transaction carries cur_x, cur_y, goal_x, goal_y.
// Output channel out_*: next_x, next_y in tdata, reached in tuser.
// cfg_wr_en/cfg_wr_data load max_step; write only while the block is idle.
// The datapath is a pipeline: delta, squares, compare, a row of
// COORD_WIDTH+1 square-root cells, a multiply stage, a row of COORD_WIDTH+1
// divider cells (x and y side by side) and the output register.
// Throughput is one transaction per cycle while out_tready is high.
// When out_tready is low with a result waiting, the whole pipeline holds
// and in_tready drops, even if some pipeline slots are empty.
// Reset clears every valid flag and sets max_step to 30.0 (480).
`default_nettype none
module move_toward_clamped_step #(
  parameter int unsigned COORD_WIDTH = mtc_pkg::CoordWidth
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  // cur_x, cur_y, goal_x, goal_y, zero pad
  input  wire logic [((4*COORD_WIDTH+7)/8)*8-1:0]    in_tdata,
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  // next_x, next_y, zero pad
  output logic [((2*COORD_WIDTH+7)/8)*8-1:0]         out_tdata,
  // reached
  output logic                                       out_tuser,
  input  wire logic                                  cfg_wr_en,
  input  wire logic [mtc_pkg::StepWidth-1:0]         cfg_wr_data
);
  localparam int unsigned W    = COORD_WIDTH;
  localparam int unsigned R    = W + 1;
  localparam int unsigned SW   = mtc_pkg::StepWidth;
  localparam int unsigned SUMW = 2*R;
  localparam int unsigned CMPW = (SUMW > 2*SW) ? SUMW : 2*SW;
  localparam int unsigned DW   = R + SW;
  localparam int unsigned OUTW = ((2*W+7)/8)*8;
  localparam int unsigned SQS  = 2*R + 2 + 4*W + 1;
  localparam int unsigned DXS  = 1 + 4*W + 1;

  logic [SW-1:0] max_step_r;
  logic          en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_step_r <= mtc_pkg::StepReset;
    end else if (cfg_wr_en) begin
      max_step_r <= cfg_wr_data;
    end
  end

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // stage 1: deltas and magnitudes
  logic signed [W-1:0] cx, cy, gx, gy;
  logic signed [R-1:0] dx, dy;
  assign cx = in_tdata[W-1:0];
  assign cy = in_tdata[2*W-1:W];
  assign gx = in_tdata[3*W-1:2*W];
  assign gy = in_tdata[4*W-1:3*W];
  assign dx = R'(gx) - R'(cx);
  assign dy = R'(gy) - R'(cy);

  logic          v1_r;
  logic [R-1:0]  ax1_r, ay1_r;
  logic          sx1_r, sy1_r;
  logic [4*W-1:0] pt1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_tvalid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ax1_r <= dx[R-1] ? R'(-dx) : R'(dx);
      ay1_r <= dy[R-1] ? R'(-dy) : R'(dy);
      sx1_r <= dx[R-1];
      sy1_r <= dy[R-1];
      pt1_r <= in_tdata[4*W-1:0];
    end
  end

  // stage 2: squares
  logic            v2_r;
  logic [2*R-1:0]  qx2_r, qy2_r;
  logic [R-1:0]    ax2_r, ay2_r;
  logic            sx2_r, sy2_r;
  logic [4*W-1:0]  pt2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      qx2_r <= ax1_r * ax1_r;
      qy2_r <= ay1_r * ay1_r;
      ax2_r <= ax1_r; ay2_r <= ay1_r;
      sx2_r <= sx1_r; sy2_r <= sy1_r;
      pt2_r <= pt1_r;
    end
  end

  // stage 3: squared distance and compare with max_step squared
  logic [SUMW-1:0] sum;
  logic [2*SW-1:0] lim;
  assign sum = qx2_r + qy2_r;
  assign lim = max_step_r * max_step_r;

  logic            v3_r;
  logic [SUMW-1:0] sum3_r;
  logic [SQS-1:0]  side3_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= v2_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sum3_r  <= sum;
      side3_r <= {CMPW'(sum) > CMPW'(lim), pt2_r, sy2_r, sx2_r, ay2_r, ax2_r};
    end
  end

  // square-root cell row
  logic            sq_v    [R+1];
  logic [2*R-1:0]  sq_rad  [R+1];
  logic [R:0]      sq_rem  [R+1];
  logic [R-1:0]    sq_root [R+1];
  logic [SQS-1:0]  sq_side [R+1];
  assign sq_v[0]    = v3_r;
  assign sq_rad[0]  = sum3_r;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_side[0] = side3_r;

  for (genvar i = 0; i < R; i++) begin : g_sqrt
    mtc_sqrt_cell #(.R(R), .SIDE_W(SQS)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .vld_i(sq_v[i]), .rad_i(sq_rad[i]), .rem_i(sq_rem[i]),
      .root_i(sq_root[i]), .side_i(sq_side[i]),
      .vld_o(sq_v[i+1]), .rad_o(sq_rad[i+1]), .rem_o(sq_rem[i+1]),
      .root_o(sq_root[i+1]), .side_o(sq_side[i+1])
    );
  end

  // multiply stage: dividends |d| * max_step
  logic [SQS-1:0] sq_end;
  assign sq_end = sq_side[R];

  logic            v4_r;
  logic [DW-1:0]   nx4_r, ny4_r;
  logic [R-1:0]    root4_r;
  logic [DXS-1:0]  sidex4_r;
  logic            sy4_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (en) v4_r <= sq_v[R];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      nx4_r    <= sq_end[R-1:0] * max_step_r;
      ny4_r    <= sq_end[2*R-1:R] * max_step_r;
      // a root of zero only occurs off the step branch; force one to keep it tidy
      root4_r  <= (sq_root[R] == '0) ? R'(1) : sq_root[R];
      sidex4_r <= {sq_end[SQS-1:2*R+2], sq_end[2*R]};
      sy4_r    <= sq_end[2*R+1];
    end
  end

  // divider cell rows; quotient fits R bits since the step never exceeds |d|
  logic           dx_v [R+1], dy_v [R+1];
  logic [R-1:0]   dx_num [R+1], dx_rem [R+1], dx_den [R+1], dx_quo [R+1];
  logic [R-1:0]   dy_num [R+1], dy_rem [R+1], dy_den [R+1], dy_quo [R+1];
  logic [DXS-1:0] dx_side [R+1];
  logic           dy_side [R+1];

  assign dx_v[0]    = v4_r;
  assign dx_num[0]  = nx4_r[R-1:0];
  assign dx_rem[0]  = R'(nx4_r >> R);
  assign dx_den[0]  = root4_r;
  assign dx_quo[0]  = '0;
  assign dx_side[0] = sidex4_r;
  assign dy_v[0]    = v4_r;
  assign dy_num[0]  = ny4_r[R-1:0];
  assign dy_rem[0]  = R'(ny4_r >> R);
  assign dy_den[0]  = root4_r;
  assign dy_quo[0]  = '0;
  assign dy_side[0] = sy4_r;

  for (genvar i = 0; i < R; i++) begin : g_div
    mtc_div_cell #(.R(R), .SIDE_W(DXS)) u_x (
      .clk(clk), .rst_n(rst_n), .en(en),
      .vld_i(dx_v[i]), .num_i(dx_num[i]), .rem_i(dx_rem[i]),
      .den_i(dx_den[i]), .quo_i(dx_quo[i]), .side_i(dx_side[i]),
      .vld_o(dx_v[i+1]), .num_o(dx_num[i+1]), .rem_o(dx_rem[i+1]),
      .den_o(dx_den[i+1]), .quo_o(dx_quo[i+1]), .side_o(dx_side[i+1])
    );
    mtc_div_cell #(.R(R), .SIDE_W(1)) u_y (
      .clk(clk), .rst_n(rst_n), .en(en),
      .vld_i(dy_v[i]), .num_i(dy_num[i]), .rem_i(dy_rem[i]),
      .den_i(dy_den[i]), .quo_i(dy_quo[i]), .side_i(dy_side[i]),
      .vld_o(dy_v[i+1]), .num_o(dy_num[i+1]), .rem_o(dy_rem[i+1]),
      .den_o(dy_den[i+1]), .quo_o(dy_quo[i+1]), .side_o(dy_side[i+1])
    );
  end

  // output stage: apply sign, add to cur, or pass goal through
  logic [DXS-1:0] fin;
  logic           beyond, sgx, sgy;
  logic [W-1:0]   fcx, fcy, fgx, fgy;
  logic [R-1:0]   stx, sty;
  logic [W-1:0]   nxt_x, nxt_y;
  assign fin    = dx_side[R];
  assign sgx    = fin[0];
  assign fcx    = fin[W:1];
  assign fcy    = fin[2*W:W+1];
  assign fgx    = fin[3*W:2*W+1];
  assign fgy    = fin[4*W:3*W+1];
  assign beyond = fin[4*W+1];
  assign sgy    = dy_side[R];
  assign stx    = sgx ? R'(-dx_quo[R]) : dx_quo[R];
  assign sty    = sgy ? R'(-dy_quo[R]) : dy_quo[R];
  assign nxt_x  = beyond ? W'(fcx + stx[W-1:0]) : fgx;
  assign nxt_y  = beyond ? W'(fcy + sty[W-1:0]) : fgy;

  logic [2*W-1:0] res_r;
  logic           reached_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_tvalid <= 1'b0;
    else if (en) out_tvalid <= dx_v[R];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      res_r     <= {nxt_y, nxt_x};
      reached_r <= !beyond;
    end
  end

  assign out_tdata = OUTW'(res_r);
  assign out_tuser = reached_r;
endmodule
`default_nettype wire
